// ===== src/lsc_pkg.sv =====
// Shared types, codes and sizes of the sector cache tag controller.
package lsc_pkg;

   localparam int MAX_LINES  = 16;
   localparam int STAMP_BITS = 64;
   localparam int IDX_BITS   = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
   localparam int CNT_BITS   = $clog2(MAX_LINES + 1);
   localparam int LIM_BITS   = (CNT_BITS > 5) ? CNT_BITS : 5;

   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_GET   = 2'd1;
   localparam logic [1:0] OP_INVAL = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_MISS  = 2'd1;
   localparam logic [1:0] ST_NOTEN = 2'd2;

   localparam logic [1:0] KIND_FILL    = 2'd0;
   localparam logic [1:0] KIND_UPDATE  = 2'd1;
   localparam logic [1:0] KIND_REPLACE = 2'd2;

   localparam logic [2:0] REG_ENABLE = 3'd0;
   localparam logic [2:0] REG_LINES  = 3'd4;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] track_number;
      logic [15:0] sector_number;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  slot;
      logic [1:0]  put_kind;
      logic [31:0] hit_count;
      logic [31:0] miss_count;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic walk_done;
   } stat_type;

endpackage

// ===== src/lsc_ctrl.sv =====
// Request sequencer: accept, line walk, commit and response strobe.
module lsc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        req_op,
   input  logic              enable,
   input  lsc_pkg::stat_type stat,
   output lsc_pkg::cmd_type  cmd,
   output logic              busy,
   output logic              rsp_strobe
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_WALK   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       strobe_ff, strobe_in;
   logic       needs_walk;

   assign needs_walk = enable && (req_op == lsc_pkg::OP_PUT || req_op == lsc_pkg::OP_GET);

   always_comb begin
      state_in    = state_ff;
      strobe_in   = 1'b0;
      cmd.capture = 1'b0;
      cmd.step    = 1'b0;
      cmd.commit  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = needs_walk ? S_WALK : S_FINISH;
            end
         end
         S_WALK: begin
            cmd.step = 1'b1;
            if (stat.walk_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            cmd.commit = 1'b1;
            strobe_in  = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe longer than one cycle");

   a_finish_strobe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH) |=> (rsp_strobe && state_ff == S_IDLE))
      else $error("commit not followed by response");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_strobe))
      else $error("accepted word did not raise busy");

endmodule

// ===== src/lsc_datapath.sv =====
// Line store, LRU walk, event and hit/miss counters, response register.
module lsc_datapath (
   input  logic                clock,
   input  logic                reset,
   input  lsc_pkg::cmd_type    cmd,
   input  lsc_pkg::req_type    req_word,
   input  logic                enable,
   input  logic [4:0]          lines_in_use,
   output lsc_pkg::stat_type   stat,
   output lsc_pkg::rsp_type    rsp_word
);

   localparam int LB = lsc_pkg::LIM_BITS;
   localparam int IB = lsc_pkg::IDX_BITS;
   localparam int SB = lsc_pkg::STAMP_BITS;
   localparam int ML = lsc_pkg::MAX_LINES;

   logic [ML-1:0] valid_ff, valid_in;
   logic [15:0]   track_ff  [ML];
   logic [15:0]   sector_ff [ML];
   logic [SB-1:0] stamp_ff  [ML];

   lsc_pkg::req_type req_ff, req_in;
   lsc_pkg::rsp_type rsp_ff, rsp_in;
   logic          refused_ff, refused_in;
   logic [IB-1:0] idx_ff, idx_in;
   logic [IB-1:0] victim_ff, victim_in;
   logic [SB-1:0] vstamp_ff, vstamp_in;
   logic [IB-1:0] slot_ff, slot_in;
   logic [1:0]    kind_ff, kind_in;
   logic          found_ff, found_in;
   logic [SB-1:0] event_ff, event_in;
   logic [31:0]   hits_ff, hits_in;
   logic [31:0]   misses_ff, misses_in;

   logic          wr_line, wr_stamp;
   logic [LB-1:0] lines_ext, lines_eff;
   logic [IB-1:0] last_idx;
   logic          cur_valid, cur_match, at_last;
   logic [SB-1:0] cur_stamp;

   always_comb begin
      lines_ext = LB'(lines_in_use);
      if (lines_ext == '0) begin
         lines_eff = LB'(1);
      end else if (lines_ext > LB'(ML)) begin
         lines_eff = LB'(ML);
      end else begin
         lines_eff = lines_ext;
      end
   end

   assign last_idx  = IB'(lines_eff - LB'(1));
   assign cur_valid = valid_ff[idx_ff];
   assign cur_stamp = stamp_ff[idx_ff];
   assign cur_match = cur_valid && track_ff[idx_ff] == req_ff.track_number
                      && sector_ff[idx_ff] == req_ff.sector_number;
   assign at_last   = (idx_ff == last_idx);

   // line walk
   always_comb begin
      req_in         = req_ff;
      refused_in     = refused_ff;
      idx_in         = idx_ff;
      victim_in      = victim_ff;
      vstamp_in      = vstamp_ff;
      slot_in        = slot_ff;
      kind_in        = kind_ff;
      found_in       = found_ff;
      stat.walk_done = 1'b0;
      if (cmd.capture) begin
         req_in     = req_word;
         refused_in = !enable;
         idx_in     = '0;
         slot_in    = '0;
         kind_in    = lsc_pkg::KIND_FILL;
         found_in   = 1'b0;
      end else if (cmd.step) begin
         idx_in = idx_ff + IB'(1);
         if (req_ff.op == lsc_pkg::OP_PUT) begin
            if (!cur_valid) begin
               stat.walk_done = 1'b1;
               slot_in        = idx_ff;
               kind_in        = lsc_pkg::KIND_FILL;
            end else if (cur_match) begin
               stat.walk_done = 1'b1;
               slot_in        = idx_ff;
               kind_in        = lsc_pkg::KIND_UPDATE;
            end else begin
               if (idx_ff == '0 || cur_stamp < vstamp_ff) begin
                  victim_in = idx_ff;
                  vstamp_in = cur_stamp;
               end
               if (at_last) begin
                  stat.walk_done = 1'b1;
                  slot_in        = victim_in;
                  kind_in        = lsc_pkg::KIND_REPLACE;
               end
            end
         end else begin
            if (cur_match) begin
               stat.walk_done = 1'b1;
               slot_in        = idx_ff;
               found_in       = 1'b1;
            end else if (at_last) begin
               stat.walk_done = 1'b1;
            end
         end
      end
   end

   // commit and response
   always_comb begin
      valid_in  = valid_ff;
      event_in  = event_ff;
      hits_in   = hits_ff;
      misses_in = misses_ff;
      wr_line   = 1'b0;
      wr_stamp  = 1'b0;
      rsp_in    = rsp_ff;
      if (cmd.commit) begin
         rsp_in.status   = lsc_pkg::ST_OK;
         rsp_in.slot     = '0;
         rsp_in.put_kind = lsc_pkg::KIND_FILL;
         if (refused_ff) begin
            rsp_in.status = lsc_pkg::ST_NOTEN;
         end else begin
            case (req_ff.op)
               lsc_pkg::OP_PUT: begin
                  wr_line           = 1'b1;
                  valid_in[slot_ff] = 1'b1;
                  event_in          = event_ff + SB'(1);
                  rsp_in.slot       = 4'(slot_ff);
                  rsp_in.put_kind   = kind_ff;
               end
               lsc_pkg::OP_GET: begin
                  if (found_ff) begin
                     wr_stamp    = 1'b1;
                     event_in    = event_ff + SB'(1);
                     rsp_in.slot = 4'(slot_ff);
                     if (hits_ff != '1) begin
                        hits_in = hits_ff + 32'd1;
                     end
                  end else begin
                     rsp_in.status = lsc_pkg::ST_MISS;
                     if (misses_ff != '1) begin
                        misses_in = misses_ff + 32'd1;
                     end
                  end
               end
               lsc_pkg::OP_INVAL: begin
                  valid_in = '0;
               end
               default: begin
               end
            endcase
         end
         rsp_in.hit_count  = hits_in;
         rsp_in.miss_count = misses_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         event_ff  <= '0;
         hits_ff   <= '0;
         misses_ff <= '0;
      end else begin
         valid_ff  <= valid_in;
         event_ff  <= event_in;
         hits_ff   <= hits_in;
         misses_ff <= misses_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      refused_ff <= refused_in;
      idx_ff     <= idx_in;
      victim_ff  <= victim_in;
      vstamp_ff  <= vstamp_in;
      slot_ff    <= slot_in;
      kind_ff    <= kind_in;
      found_ff   <= found_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_line) begin
         track_ff[slot_ff]  <= req_ff.track_number;
         sector_ff[slot_ff] <= req_ff.sector_number;
      end
      if (wr_line || wr_stamp) begin
         stamp_ff[slot_ff] <= event_ff;
      end
   end

   assign rsp_word = rsp_ff;

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (idx_ff <= last_idx))
      else $error("line walk beyond lines in use");

   a_walk_ends: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && at_last) |-> stat.walk_done)
      else $error("line walk did not end at last line");

endmodule

// ===== src/lru_sector_cache_controller.sv =====
// Top level of the fully associative LRU sector cache tag controller.
//
//  channel  | handshake               | word
//  ---------+-------------------------+---------------------------------------
//  request  | start && !busy          | req_word (op, track, sector)
//  response | rsp_strobe, one cycle   | rsp_word (status, slot, kind, counts)
//  csr      | psel&penable&pwrite     | paddr 0: enable, 4: lines in use
//
//  A put or get walks one line per cycle until it ends, at most lines in use,
//  then commits, and strobes the response in the next cycle; the next word
//  can be taken in the strobe cycle. Disabled, invalidate and unknown
//  requests skip the walk and go straight to the commit.
//  Synchronous reset clears valid bits, counters and the sequencer.
//  The receiver cannot stall; busy holds off requests until the commit.
module lru_sector_cache_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lsc_pkg::req_type req_word,
   output logic             rsp_strobe,
   output lsc_pkg::rsp_type rsp_word,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic       enable_ff, enable_in;
   logic [4:0] lines_ff, lines_in;
   logic       csr_write;

   lsc_pkg::cmd_type  cmd;
   lsc_pkg::stat_type stat;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      enable_in = enable_ff;
      lines_in  = lines_ff;
      if (csr_write) begin
         case ({paddr[2], 2'b00})
            lsc_pkg::REG_ENABLE: enable_in = pwdata[0];
            lsc_pkg::REG_LINES:  lines_in  = pwdata[4:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         lines_ff  <= 5'd16;
      end else begin
         enable_ff <= enable_in;
         lines_ff  <= lines_in;
      end
   end

   always_comb begin
      case ({paddr[2], 2'b00})
         lsc_pkg::REG_ENABLE: prdata = {31'd0, enable_ff};
         lsc_pkg::REG_LINES:  prdata = {27'd0, lines_ff};
         default:             prdata = '0;
      endcase
   end

   lsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_op     (req_word.op),
      .enable     (enable_ff),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   lsc_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_word     (req_word),
      .enable       (enable_ff),
      .lines_in_use (lines_ff),
      .stat         (stat),
      .rsp_word     (rsp_word)
   );

endmodule
